@@ hdl/cerag_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerag_pkg
// Shared types and codes for the CSR edge reader address generator.
// ----------------------------------------------------------------------------
package cerag_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_BASE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_TOTAL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_ROW    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_ROW     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_BASE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_COUNT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BYTES   = 3'd6;

    localparam logic [1:0] FUNC_ROW_POINTER = 2'd0;
    localparam logic [1:0] FUNC_COLUMN      = 2'd1;
    localparam logic [1:0] FUNC_TRANSFER    = 2'd2;
    localparam logic [1:0] FUNC_ISSUE       = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
        logic        line_last;
    } req_item_t;

    typedef struct packed {
        logic [31:0] row_index;
        logic [31:0] column_index;
        logic [7:0]  fold_index;
        logic [47:0] address;
        logic        row_end;
        logic [7:0]  skipped_outputs;
        logic        request_needed;
        logic        row_ready;
        logic        all_requested;
        logic        all_consumed;
        logic        queue_empty;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic mul;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic xfer_go;
    } status_t;

endpackage

@@ hdl/cerag_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerag_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cerag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/cerag_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerag_ctrl
// Sequencer: accept a request, run the datapath steps, commit the result.
// ----------------------------------------------------------------------------
module cerag_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  cerag_pkg::status_t status,
    output cerag_pkg::cmd_t   cmd
);
    import cerag_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   commit_ok;

    assign commit_ok = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (req_valid) state_next = ST_EXEC;
            ST_EXEC:   state_next = status.xfer_go ? ST_MUL : ST_COMMIT;
            ST_MUL:    state_next = ST_COMMIT;
            ST_COMMIT: if (commit_ok) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && req_valid;
        cmd.exec   = (state_reg == ST_EXEC);
        cmd.mul    = (state_reg == ST_MUL);
        cmd.commit = (state_reg == ST_COMMIT) && commit_ok;
        req_stall  = (state_reg != ST_IDLE);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/cerag_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerag_dp
// Datapath: configuration, column queue, row and credit counters, address math.
// ----------------------------------------------------------------------------
module cerag_dp #(
    parameter int QUEUE_DEPTH   = 512,
    parameter int LINE_ELEMENTS = 16,
    parameter int INDEX_WIDTH   = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cerag_pkg::req_item_t                   req_data,
    output cerag_pkg::rsp_item_t                   rsp_data,
    input  logic                                   cfg_we,
    input  logic [cerag_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cerag_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  cerag_pkg::cmd_t                        cmd,
    output cerag_pkg::status_t                     status
);
    import cerag_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QR_W  = $clog2(2 * QUEUE_DEPTH);
    localparam int CMP_W = QR_W + 8;
    localparam logic [CMP_W-1:0] QD_C   = CMP_W'(QUEUE_DEPTH);
    localparam logic [CMP_W-1:0] LE_C   = CMP_W'(LINE_ELEMENTS);
    localparam logic [CMP_W-1:0] CAP_C  = CMP_W'(2 * QUEUE_DEPTH - 1);
    localparam logic [PTR_W-1:0] LAST_P = PTR_W'(QUEUE_DEPTH - 1);

    // configuration
    logic [47:0] col_base_reg, col_base_next;
    logic [23:0] line_total_reg, line_total_next;
    logic [31:0] first_row_reg, first_row_next;
    logic [31:0] last_row_reg, last_row_next;
    logic [47:0] feat_base_reg, feat_base_next;
    logic [7:0]  fold_count_reg, fold_count_next;
    logic [8:0]  line_bytes_reg, line_bytes_next;

    // walker state
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [INDEX_WIDTH-1:0] cur_col_reg, cur_col_next;
    logic [31:0]            last_ptr_reg, last_ptr_next;
    logic [31:0]            cols_left_reg, cols_left_next;
    logic [31:0]            row_cols_reg, row_cols_next;
    logic [31:0]            row_cnt_reg, row_cnt_next;
    logic [7:0]             fold_reg, fold_next;
    logic [QR_W-1:0]        qres_reg, qres_next;
    logic [23:0]            lreq_reg, lreq_next;
    logic [23:0]            lrcv_reg, lrcv_next;
    logic                   need_reg, need_next;
    logic                   empty_reg, empty_next;
    logic                   ready_reg, ready_next;
    logic [47:0]            rd_ptr_reg, rd_ptr_next;

    // item and arithmetic pipeline
    req_item_t              item_reg;
    logic [INDEX_WIDTH-1:0] col_op_reg;
    logic [39:0]            prod1_reg;
    logic [47:0]            prod2_reg;
    rsp_item_t              out_reg, out_next;

    logic [INDEX_WIDTH-1:0] ram_rdata;
    logic                   ram_we;
    logic [INDEX_WIDTH-1:0] col_op;
    logic [7:0]             folds;
    logic [CMP_W-1:0]       free_now;
    logic [CMP_W-1:0]       free_new;
    logic [CMP_W-1:0]       qr_sum;
    logic [CMP_W-1:0]       qr_cap;
    logic [8:0]             fold_inc;
    logic [31:0]            diff;
    logic [31:0]            qres_wide;
    logic [50:0]            prod2_full;

    cerag_ram #(
        .WIDTH(INDEX_WIDTH),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(item_reg.value[INDEX_WIDTH-1:0]),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    assign folds  = (fold_count_reg == 8'd0) ? 8'd1 : fold_count_reg;
    assign status.xfer_go = (item_reg.func == FUNC_TRANSFER) && (cols_left_reg != 32'd0)
                            && !((fold_reg == 8'd0) && (count_reg == CNT_W'(0)));
    // first fold of a column takes the queue head, later folds reuse it
    assign col_op = (fold_reg == 8'd0) ? ram_rdata : cur_col_reg;
    assign free_now = (CMP_W'(qres_reg) >= QD_C) ? '0 : QD_C - CMP_W'(qres_reg);
    assign qr_sum   = CMP_W'(qres_reg) + LE_C;
    assign qr_cap   = (qr_sum > CAP_C) ? CAP_C : qr_sum;
    assign free_new = (qr_cap >= QD_C) ? '0 : QD_C - qr_cap;
    assign fold_inc = {1'b0, fold_reg} + 9'd1;
    assign diff     = item_reg.value - last_ptr_reg;
    assign qres_wide = 32'(qres_reg);
    assign prod2_full = (51'(prod1_reg) + 51'(fold_reg)) * 51'(line_bytes_reg);
    assign ram_we = cmd.commit && (item_reg.func == FUNC_COLUMN)
                    && (count_reg < CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        col_base_next   = col_base_reg;
        line_total_next = line_total_reg;
        first_row_next  = first_row_reg;
        last_row_next   = last_row_reg;
        feat_base_next  = feat_base_reg;
        fold_count_next = fold_count_reg;
        line_bytes_next = line_bytes_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        cur_col_next    = cur_col_reg;
        last_ptr_next   = last_ptr_reg;
        cols_left_next  = cols_left_reg;
        row_cols_next   = row_cols_reg;
        row_cnt_next    = row_cnt_reg;
        fold_next       = fold_reg;
        qres_next       = qres_reg;
        lreq_next       = lreq_reg;
        lrcv_next       = lrcv_reg;
        need_next       = need_reg;
        empty_next      = empty_reg;
        ready_next      = ready_reg;
        rd_ptr_next     = rd_ptr_reg;
        out_next        = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMN_BASE:
                begin
                    col_base_next = cfg_data;
                    rd_ptr_next   = cfg_data;
                end
                CFG_LINE_TOTAL:   line_total_next = cfg_data[23:0];
                CFG_FIRST_ROW:
                begin
                    first_row_next = cfg_data[31:0];
                    row_cnt_next   = cfg_data[31:0] - 32'd1;
                end
                CFG_LAST_ROW:     last_row_next   = cfg_data[31:0];
                CFG_FEATURE_BASE: feat_base_next  = cfg_data;
                CFG_FOLD_COUNT:   fold_count_next = cfg_data[7:0];
                CFG_LINE_BYTES:   line_bytes_next = cfg_data[8:0];
                default:          ;
            endcase
        end

        if (cmd.commit)
        begin
            out_next = '0;
            unique case (item_reg.func)
                FUNC_ROW_POINTER:
                begin
                    if (ready_reg)
                    begin
                        last_ptr_next  = item_reg.value;
                        cols_left_next = diff;
                        row_cols_next  = diff;
                        row_cnt_next   = row_cnt_reg + 32'd1;
                        ready_next     = 1'b0;
                        if (diff == 32'd0)
                        begin
                            out_next.skipped_outputs = folds;
                            ready_next = 1'b1;
                        end
                    end
                end
                FUNC_COLUMN:
                begin
                    if (count_reg < CNT_W'(QUEUE_DEPTH))
                    begin
                        tail_next  = (tail_reg == LAST_P) ? '0 : tail_reg + PTR_W'(1);
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (item_reg.line_last && (lrcv_reg != 24'hFFFFFF))
                    begin
                        lrcv_next = lrcv_reg + 24'd1;
                    end
                    empty_next = 1'b0;
                end
                FUNC_TRANSFER:
                begin
                    if (status.xfer_go)
                    begin
                        if (fold_reg == 8'd0)
                        begin
                            cur_col_next = col_op_reg;
                            head_next    = (head_reg == LAST_P) ? '0 : head_reg + PTR_W'(1);
                            count_next   = count_reg - CNT_W'(1);
                        end
                        out_next.row_index    = row_cnt_reg;
                        out_next.column_index = 32'(col_op_reg);
                        out_next.fold_index   = fold_reg;
                        out_next.address      = feat_base_reg + prod2_reg;
                        if ((lreq_reg < line_total_reg) && (free_now > LE_C))
                        begin
                            need_next = 1'b1;
                        end
                        fold_next = fold_inc[7:0];
                        if (cols_left_reg == 32'd1)
                        begin
                            out_next.row_end = 1'b1;
                            if (fold_inc >= {1'b0, folds})
                            begin
                                qres_next = (qres_wide > row_cols_reg)
                                            ? QR_W'(qres_wide - row_cols_reg) : '0;
                                fold_next      = 8'd0;
                                cols_left_next = 32'd0;
                                if (row_cnt_reg != last_row_reg)
                                begin
                                    ready_next = 1'b1;
                                end
                                else
                                begin
                                    empty_next = 1'b1;
                                end
                            end
                        end
                        else if (fold_inc >= {1'b0, folds})
                        begin
                            fold_next      = 8'd0;
                            cols_left_next = cols_left_reg - 32'd1;
                        end
                        if ((fold_next == 8'd0) && (count_next == CNT_W'(0)))
                        begin
                            empty_next = 1'b1;
                        end
                    end
                end
                FUNC_ISSUE:
                begin
                    if (lreq_reg < line_total_reg)
                    begin
                        qres_next = QR_W'(qr_cap);
                        lreq_next = lreq_reg + 24'd1;
                        if ((free_new < LE_C) || (lreq_next == line_total_reg))
                        begin
                            need_next = 1'b0;
                        end
                        out_next.address = rd_ptr_reg;
                        rd_ptr_next = rd_ptr_reg + 48'(line_bytes_reg);
                    end
                end
                default: ;
            endcase
            out_next.request_needed = need_next;
            out_next.row_ready      = ready_next;
            out_next.all_requested  = (lreq_next == line_total_reg);
            out_next.all_consumed   = (lrcv_next == line_total_reg) && empty_next;
            out_next.queue_empty    = empty_next;
        end
    end

    assign rsp_data = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req_data;
        end
        if (cmd.exec)
        begin
            col_op_reg <= col_op;
            prod1_reg  <= 40'(col_op) * 40'(folds);
        end
        if (cmd.mul)
        begin
            prod2_reg <= prod2_full[47:0];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_base_reg   <= '0;
            line_total_reg <= '0;
            first_row_reg  <= '0;
            last_row_reg   <= '0;
            feat_base_reg  <= '0;
            fold_count_reg <= 8'd1;
            line_bytes_reg <= 9'd64;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            cur_col_reg    <= '0;
            last_ptr_reg   <= '0;
            cols_left_reg  <= '0;
            row_cols_reg   <= '0;
            row_cnt_reg    <= '1;
            fold_reg       <= '0;
            qres_reg       <= '0;
            lreq_reg       <= '0;
            lrcv_reg       <= '0;
            need_reg       <= 1'b1;
            empty_reg      <= 1'b1;
            ready_reg      <= 1'b1;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            col_base_reg   <= col_base_next;
            line_total_reg <= line_total_next;
            first_row_reg  <= first_row_next;
            last_row_reg   <= last_row_next;
            feat_base_reg  <= feat_base_next;
            fold_count_reg <= fold_count_next;
            line_bytes_reg <= line_bytes_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            cur_col_reg    <= cur_col_next;
            last_ptr_reg   <= last_ptr_next;
            cols_left_reg  <= cols_left_next;
            row_cols_reg   <= row_cols_next;
            row_cnt_reg    <= row_cnt_next;
            fold_reg       <= fold_next;
            qres_reg       <= qres_next;
            lreq_reg       <= lreq_next;
            lrcv_reg       <= lrcv_next;
            need_reg       <= need_next;
            empty_reg      <= empty_next;
            ready_reg      <= ready_next;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

endmodule

@@ hdl/csr_edge_reader_address_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_edge_reader_address_gen
// CSR sparse-row walker: column queue plus feature and line address generator.
// ----------------------------------------------------------------------------
// Usage:
//   Each request (req_valid/req_stall/req_data) is a row pointer, a column
//   arrival, a transfer step or a read issue step. Every request yields
//   exactly one response on rsp_valid/rsp_stall/rsp_data carrying the
//   transfer fields or line address plus the walker status flags.
//   Configuration (cfg_we/cfg_index/cfg_data) must be written by the user
//   only while idle; the block does not enforce this. Writing the column
//   base reloads the read pointer; writing first_row reloads the row counter.
// Timing:
//   A transfer that emits an address presents its response after the
//   execute state (queue read, column times folds multiply), the multiply
//   state (times line-bytes multiply) and commit; all other requests skip
//   the multiply state. One request is in flight at a time, so a new
//   request is accepted only after the current one has committed, and
//   commit waits while a held response has not been taken.
// Reset:
//   rst_n clears all counters and flags to their idle values and the
//   registers to their defaults; the queue contents stay undefined.
// Stall:
//   A stalled response holds in the output register; the next request is
//   still accepted and holds at its commit step until the response is taken.
// ----------------------------------------------------------------------------
module csr_edge_reader_address_gen #(
    parameter int QUEUE_DEPTH   = 512,
    parameter int LINE_ELEMENTS = 16,
    parameter int INDEX_WIDTH   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  cerag_pkg::req_item_t              req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output cerag_pkg::rsp_item_t              rsp_data,
    input  logic                              cfg_we,
    input  logic [cerag_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cerag_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cerag_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequence each request: accept, execute, multiply (address-emitting transfers only), commit
    cerag_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // hold queue, counters, flags and the address multiply chain
    cerag_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .LINE_ELEMENTS(LINE_ELEMENTS),
        .INDEX_WIDTH  (INDEX_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .rsp_data (rsp_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

@@ test/tb_csr_edge_reader_address_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csr_edge_reader_address_gen
// Self-checking bench for the CSR row walker. The bench keeps its own copy of
// the walker's queue, row, credit and line counters, uses it to compute the
// response each accepted request should produce, and compares the responses
// field by field. Stimulus is short directed runs, then randomized
// row-walk sequences under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_csr_edge_reader_address_gen;
    import cerag_pkg::*;

    localparam int QDEPTH = 512;
    localparam int LINE_ELEMS = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_item_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_item_t rsp_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    csr_edge_reader_address_gen i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Walker copy: registers and state
    logic [47:0] m_col_base, m_feat_base, m_read_ptr;
    logic [23:0] m_line_total, m_lines_req, m_lines_rcv;
    logic [31:0] m_first_row, m_last_row, m_row_counter;
    logic [7:0]  m_folds, m_fold_ctr;
    logic [8:0]  m_line_bytes;
    logic [31:0] m_fifo[$];
    logic [31:0] m_cur_col, m_last_ptr, m_cols_left, m_row_cols;
    int unsigned m_reserved;
    bit m_need_req, m_empty, m_ready;

    req_item_t   pending_requests[$];
    rsp_item_t   expected_responses[$];
    int sender_idle_pct, receiver_idle_pct;
    int error_count = 0;
    bit hold_requests = 1'b0;

    // Acceptance as seen at the last rising edge, for the driver below
    logic req_stall_q = 1'b0;

    function automatic void walker_reset();
        m_col_base = '0; m_line_total = '0; m_first_row = '0; m_last_row = '0;
        m_feat_base = '0; m_folds = 8'd1; m_line_bytes = 9'd64;
        m_fifo.delete();
        m_cur_col = '0; m_last_ptr = '0; m_cols_left = '0; m_row_cols = '0;
        m_row_counter = 32'hFFFF_FFFF; m_fold_ctr = '0; m_reserved = 0;
        m_lines_req = '0; m_lines_rcv = '0;
        m_need_req = 1'b1; m_empty = 1'b1; m_ready = 1'b1; m_read_ptr = '0;
    endfunction

    function automatic int unsigned credit_free();
        return (m_reserved >= QDEPTH) ? 0 : QDEPTH - m_reserved;
    endfunction

    // Compute the response for one accepted request and advance the copy
    function automatic rsp_item_t walk_step(req_item_t rq);
        rsp_item_t r;
        logic [31:0] diff;
        logic [7:0] folds;
        r = '0;
        folds = (m_folds == 0) ? 8'd1 : m_folds;
        case (rq.func)
            FUNC_ROW_POINTER:
                if (m_ready)
                begin
                    diff = rq.value - m_last_ptr;
                    m_last_ptr = rq.value;
                    m_cols_left = diff;
                    m_row_cols = diff;
                    m_row_counter = m_row_counter + 32'd1;
                    m_ready = 1'b0;
                    if (diff == 0)
                    begin
                        r.skipped_outputs = folds;
                        m_ready = 1'b1;
                    end
                end
            FUNC_COLUMN:
            begin
                if (m_fifo.size() < QDEPTH)
                    m_fifo = {m_fifo, rq.value};
                if (rq.line_last && m_lines_rcv != 24'hFF_FFFF)
                    m_lines_rcv = m_lines_rcv + 24'd1;
                m_empty = 1'b0;
            end
            FUNC_TRANSFER:
                if (m_cols_left != 0 && !(m_fold_ctr == 0 && m_fifo.size() == 0))
                begin
                    if (m_fold_ctr == 0)
                        m_cur_col = m_fifo.pop_front();
                    r.row_index = m_row_counter;
                    r.column_index = m_cur_col;
                    r.fold_index = m_fold_ctr;
                    r.address = 48'(m_feat_base + (64'(m_cur_col) * folds + m_fold_ctr)
                        * m_line_bytes);
                    if (m_lines_req < m_line_total && credit_free() > LINE_ELEMS)
                        m_need_req = 1'b1;
                    m_fold_ctr = m_fold_ctr + 8'd1;
                    if (m_cols_left == 1)
                    begin
                        r.row_end = 1'b1;
                        if (m_fold_ctr >= folds)
                        begin
                            m_reserved = (m_reserved > m_row_cols) ? m_reserved - m_row_cols : 0;
                            m_fold_ctr = '0;
                            m_cols_left = '0;
                            if (m_row_counter != m_last_row)
                                m_ready = 1'b1;
                            else
                                m_empty = 1'b1;
                        end
                    end
                    else if (m_fold_ctr >= folds)
                    begin
                        m_fold_ctr = '0;
                        m_cols_left = m_cols_left - 32'd1;
                    end
                    if (m_fold_ctr == 0 && m_fifo.size() == 0)
                        m_empty = 1'b1;
                end
            default:
                if (m_lines_req < m_line_total)
                begin
                    m_reserved = (m_reserved + LINE_ELEMS > 2 * QDEPTH - 1)
                        ? 2 * QDEPTH - 1 : m_reserved + LINE_ELEMS;
                    m_lines_req = m_lines_req + 24'd1;
                    if (credit_free() < LINE_ELEMS || m_lines_req == m_line_total)
                        m_need_req = 1'b0;
                    r.address = m_read_ptr;
                    m_read_ptr = m_read_ptr + 48'(m_line_bytes);
                end
        endcase
        r.request_needed = m_need_req;
        r.row_ready = m_ready;
        r.all_requested = (m_lines_req == m_line_total);
        r.all_consumed = (m_lines_rcv == m_line_total) && m_empty;
        r.queue_empty = m_empty;
        return r;
    endfunction

    // Driver: present the next pending request, hold it while stalled
    always @(negedge clk)
    begin
        if (req_valid && !req_stall_q)
        begin
            if (!hold_requests && pending_requests.size() != 0
                && $urandom_range(99) >= sender_idle_pct)
                req_data <= pending_requests.pop_front();
            else
                req_valid <= 1'b0;
        end
        else if (!req_valid && !hold_requests && pending_requests.size() != 0
                 && $urandom_range(99) >= sender_idle_pct)
        begin
            req_data <= pending_requests.pop_front();
            req_valid <= 1'b1;
        end
        rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk)
        req_stall_q <= req_stall;

    // Monitor: predict on request accept, check on response accept
    always @(posedge clk)
    begin
        rsp_item_t exp_r;
        if (rst_n && req_valid && !req_stall)
            expected_responses = {expected_responses, walk_step(req_data)};
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("response with nothing expected: %h", rsp_data);
                error_count++;
            end
            else
            begin
                exp_r = expected_responses.pop_front();
                if (exp_r.row_index !== rsp_data.row_index) begin $error("row_index exp %h got %h", exp_r.row_index, rsp_data.row_index); error_count++; end
                if (exp_r.column_index !== rsp_data.column_index) begin $error("column_index exp %h got %h", exp_r.column_index, rsp_data.column_index); error_count++; end
                if (exp_r.fold_index !== rsp_data.fold_index) begin $error("fold_index exp %h got %h", exp_r.fold_index, rsp_data.fold_index); error_count++; end
                if (exp_r.address !== rsp_data.address) begin $error("address exp %h got %h", exp_r.address, rsp_data.address); error_count++; end
                if (exp_r.row_end !== rsp_data.row_end) begin $error("row_end exp %h got %h", exp_r.row_end, rsp_data.row_end); error_count++; end
                if (exp_r.skipped_outputs !== rsp_data.skipped_outputs) begin $error("skipped_outputs exp %h got %h", exp_r.skipped_outputs, rsp_data.skipped_outputs); error_count++; end
                if (exp_r.request_needed !== rsp_data.request_needed) begin $error("request_needed exp %h got %h", exp_r.request_needed, rsp_data.request_needed); error_count++; end
                if (exp_r.row_ready !== rsp_data.row_ready) begin $error("row_ready exp %h got %h", exp_r.row_ready, rsp_data.row_ready); error_count++; end
                if (exp_r.all_requested !== rsp_data.all_requested) begin $error("all_requested exp %h got %h", exp_r.all_requested, rsp_data.all_requested); error_count++; end
                if (exp_r.all_consumed !== rsp_data.all_consumed) begin $error("all_consumed exp %h got %h", exp_r.all_consumed, rsp_data.all_consumed); error_count++; end
                if (exp_r.queue_empty !== rsp_data.queue_empty) begin $error("queue_empty exp %h got %h", exp_r.queue_empty, rsp_data.queue_empty); error_count++; end
            end
        end
    end

    function automatic void add_request(logic [1:0] f, logic [31:0] v, logic ll);
        req_item_t rq;
        rq.func = f;
        rq.value = v;
        rq.line_last = ll;
        pending_requests = {pending_requests, rq};
    endfunction

    // Write one register at a falling edge, mirror it in the copy
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [47:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COLUMN_BASE:  begin m_col_base = val; m_read_ptr = val; end
            CFG_LINE_TOTAL:   m_line_total = val[23:0];
            CFG_FIRST_ROW:    begin m_first_row = val[31:0]; m_row_counter = val[31:0] - 32'd1; end
            CFG_LAST_ROW:     m_last_row = val[31:0];
            CFG_FEATURE_BASE: m_feat_base = val;
            CFG_FOLD_COUNT:   m_folds = val[7:0];
            default:          m_line_bytes = val[8:0];
        endcase
    endtask

    // Wait until everything queued has been accepted and answered
    task automatic drain();
        while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // One well-formed row: an issue, columns, pointer, then transfers covering all folds
    task automatic add_row_walk(ref logic [31:0] ptr, input int ncols, input int folds);
        int k;
        ptr = ptr + 32'(ncols);
        add_request(FUNC_ISSUE, $urandom, 1'($urandom_range(1)));
        for (k = 0; k < ncols; k++)
            add_request(FUNC_COLUMN, $urandom, (k == ncols - 1) || ($urandom_range(3) == 0));
        add_request(FUNC_ROW_POINTER, ptr, 1'($urandom_range(1)));
        for (k = 0; k < ncols * folds; k++)
            add_request(FUNC_TRANSFER, $urandom, 1'($urandom_range(1)));
        if ($urandom_range(3) == 0)
            add_request(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
    endtask

    task automatic random_phase(int count, int folds);
        logic [31:0] ptr;
        int n;
        ptr = m_last_ptr;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(4) == 0)
            begin
                add_request(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
                n++;
            end
            else
            begin
                int nc;
                nc = $urandom_range(4);
                add_row_walk(ptr, nc, folds);
                n += 2 + nc * (folds + 1);
            end
        end
    endtask

    initial
    begin
        walker_reset();
        sender_idle_pct = 11;
        receiver_idle_pct = 52;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: defaults first, empty row, ignored transfer, issue after end
        add_request(FUNC_TRANSFER, 32'h0, 1'b0);
        add_request(FUNC_ISSUE, 32'h0, 1'b0);
        add_request(FUNC_ROW_POINTER, 32'h0, 1'b0);
        add_request(FUNC_COLUMN, 32'hFFFF_FFFF, 1'b1);
        add_request(FUNC_ROW_POINTER, 32'h1, 1'b1);
        add_request(FUNC_ROW_POINTER, 32'h5, 1'b0);
        add_request(FUNC_TRANSFER, 32'hFFFF_FFFF, 1'b1);
        add_request(FUNC_TRANSFER, 32'h0, 1'b0);
        drain();

        // Extremes of every register; zero fold count acts as one
        write_reg(CFG_COLUMN_BASE, 48'hFFFF_FFFF_FFC0);
        write_reg(CFG_LINE_TOTAL, 48'd3);
        write_reg(CFG_FIRST_ROW, 48'hFFFF_FFFF);
        write_reg(CFG_LAST_ROW, 48'h0000_0001);
        write_reg(CFG_FEATURE_BASE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_FOLD_COUNT, 48'd0);
        write_reg(CFG_LINE_BYTES, 48'd256);
        add_request(FUNC_ISSUE, 32'h0, 1'b0);
        add_request(FUNC_ISSUE, 32'h0, 1'b0);
        add_request(FUNC_ISSUE, 32'h0, 1'b0);
        add_request(FUNC_ISSUE, 32'h0, 1'b0);
        add_request(FUNC_COLUMN, 32'hFFFF_FFFF, 1'b0);
        add_request(FUNC_COLUMN, 32'h0, 1'b1);
        add_request(FUNC_ROW_POINTER, 32'h0000_0003, 1'b0);
        add_request(FUNC_TRANSFER, 32'h0, 1'b0);
        add_request(FUNC_TRANSFER, 32'h0, 1'b0);
        add_request(FUNC_ROW_POINTER, 32'h0000_0002, 1'b0);
        drain();

        // Full FIFO: overfill, then two transfers
        write_reg(CFG_FOLD_COUNT, 48'd255);
        write_reg(CFG_LINE_BYTES, 48'd1);
        for (int k = 0; k < QDEPTH + 3; k++)
            add_request(FUNC_COLUMN, $urandom, k[3:0] == 4'hF);
        add_request(FUNC_TRANSFER, 32'h0, 1'b0);
        add_request(FUNC_TRANSFER, 32'h0, 1'b0);
        receiver_idle_pct = 0;
        sender_idle_pct = 0;
        drain();

        // Fresh walk for the random phases
        sender_idle_pct = 11;
        receiver_idle_pct = 52;
        write_reg(CFG_FIRST_ROW, 48'd0);
        write_reg(CFG_LAST_ROW, 48'hFFFF_FFFF);
        write_reg(CFG_FOLD_COUNT, 48'd2);
        write_reg(CFG_LINE_BYTES, 48'd64);
        write_reg(CFG_LINE_TOTAL, 48'hFF_FFFF);
        write_reg(CFG_COLUMN_BASE, 48'($urandom));
        write_reg(CFG_FEATURE_BASE, 48'({$urandom, $urandom}));
        random_phase(40, 2);
        drain();

        sender_idle_pct = 52;
        receiver_idle_pct = 11;
        write_reg(CFG_FOLD_COUNT, 48'd1);
        write_reg(CFG_LINE_BYTES, 48'($urandom_range(1, 256)));
        write_reg(CFG_LINE_TOTAL, 48'd20);
        random_phase(40, 1);
        // Pause the sender until the block has answered everything so far
        hold_requests = 1'b1;
        while (req_valid || expected_responses.size() != 0)
            @(posedge clk);
        hold_requests = 1'b0;
        drain();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_reg(CFG_FOLD_COUNT, 48'd3);
        write_reg(CFG_LINE_BYTES, 48'd256);
        random_phase(40, 3);
        drain();

        if (error_count == 0)
            $display("tb_csr_edge_reader_address_gen: done, clean");
        else
            $display("tb_csr_edge_reader_address_gen: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_csr_edge_reader_address_gen: done, errors");
        $finish;
    end

endmodule
